// ===== hdl/tkds_pkg.sv =====
package tkds_pkg;

   localparam int KEEP_MAX        = 8;
   localparam int TILE_INDEX_BITS = 16;

   localparam int COLOUR_W  = 8;
   localparam int DIFF_W    = COLOUR_W + 1;
   localparam int LUMA_W    = 25;
   localparam int MAG_W     = LUMA_W - 1;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int ROUND_SH  = 26;
   localparam int CHAN_W    = 18;
   localparam int FRAC_W    = 8;
   localparam int TERM_W    = 27;
   localparam int SCORE_W   = 36;
   localparam int TILE_W    = TILE_INDEX_BITS;
   localparam int NUMBER_W  = 16;
   localparam int PLACE_W   = 3;
   localparam int CFG_W     = 4;
   localparam int CNT_W     = $clog2(KEEP_MAX + 1);

   localparam logic signed [LUMA_W-1:0] LUMA_WR = 25'sd13933;
   localparam logic signed [LUMA_W-1:0] LUMA_WG = 25'sd46871;
   localparam logic signed [LUMA_W-1:0] LUMA_WB = 25'sd4732;

   localparam logic [SCORE_W-1:0] SCORE_MAX     = {SCORE_W{1'b1}};
   localparam logic [CFG_W-1:0]   BEST_COUNT_RST = 4'd8;

   typedef struct packed {
      logic [COLOUR_W-1:0] query_red;
      logic [COLOUR_W-1:0] query_green;
      logic [COLOUR_W-1:0] query_blue;
      logic [COLOUR_W-1:0] cand_red;
      logic [COLOUR_W-1:0] cand_green;
      logic [COLOUR_W-1:0] cand_blue;
      logic [NUMBER_W-1:0] cand_number;
      logic                last_pixel;
      logic                last_tile;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0]  rank_score;
      logic [NUMBER_W-1:0] rank_tile;
      logic [PLACE_W-1:0]  rank_place;
      logic                last_result;
   } rsp_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile;
      logic              last_pixel;
      logic              last_tile;
   } tile_ctrl_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [TILE_W-1:0]  tile;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_OUT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cell_cmd_type;

endpackage

// ===== hdl/tkds_pixel_term.sv =====
module tkds_pixel_term (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tkds_pkg::req_type      in_data,
   output logic                   term_valid,
   output logic [tkds_pkg::TERM_W-1:0] term,
   output tkds_pkg::tile_ctrl_type term_ctrl,
   output logic                   end_pending
);
   import tkds_pkg::*;

   logic [3:0] valid_ff, valid_in;
   tile_ctrl_type ctrl_ff [4];
   tile_ctrl_type ctrl_in;

   logic signed [DIFF_W-1:0] dr_ff, dg_ff, db_ff;
   logic signed [DIFF_W-1:0] dr_in, dg_in, db_in;

   logic signed [LUMA_W-1:0] dr_x, dg_x, db_x, luma;
   logic signed [CHAN_W-1:0] rs_x, gs_x, bs_x;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [CHAN_W-1:0] chan2_ff, chan2_in;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CHAN_W-1:0] chan3_ff;

   logic [PROD_W-1:0] rounded;
   logic [TERM_W-1:0] term_ff, term_in;

   always_comb begin
      valid_in = {valid_ff[2:0], in_valid};
      ctrl_in.tile       = TILE_W'(in_data.cand_number);
      ctrl_in.last_pixel = in_data.last_pixel;
      ctrl_in.last_tile  = in_data.last_tile;
      dr_in = $signed({1'b0, in_data.query_red})   - $signed({1'b0, in_data.cand_red});
      dg_in = $signed({1'b0, in_data.query_green}) - $signed({1'b0, in_data.cand_green});
      db_in = $signed({1'b0, in_data.query_blue})  - $signed({1'b0, in_data.cand_blue});

      dr_x = LUMA_W'(dr_ff);
      dg_x = LUMA_W'(dg_ff);
      db_x = LUMA_W'(db_ff);
      luma = LUMA_WR * dr_x + LUMA_WG * dg_x + LUMA_WB * db_x;
      mag_in = luma[LUMA_W-1] ? MAG_W'(-luma) : MAG_W'(luma);
      rs_x = CHAN_W'(dr_ff);
      gs_x = CHAN_W'(dg_ff);
      bs_x = CHAN_W'(db_ff);
      chan2_in = CHAN_W'(rs_x * rs_x) + CHAN_W'(gs_x * gs_x) + CHAN_W'(bs_x * bs_x);

      prod_in = PROD_W'(mag_ff) * PROD_W'(mag_ff);

      rounded = prod_ff + (PROD_W'(1) << (ROUND_SH - 1));
      term_in = TERM_W'(rounded >> ROUND_SH) + (TERM_W'(chan3_ff) << FRAC_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff[0] <= ctrl_in;
      ctrl_ff[1] <= ctrl_ff[0];
      ctrl_ff[2] <= ctrl_ff[1];
      ctrl_ff[3] <= ctrl_ff[2];
      dr_ff      <= dr_in;
      dg_ff      <= dg_in;
      db_ff      <= db_in;
      mag_ff     <= mag_in;
      chan2_ff   <= chan2_in;
      prod_ff    <= prod_in;
      chan3_ff   <= chan2_ff;
      term_ff    <= term_in;
   end

   always_comb begin
      end_pending = 1'b0;
      for (int s = 0; s < 4; s++) begin
         if (valid_ff[s] && ctrl_ff[s].last_pixel && ctrl_ff[s].last_tile) begin
            end_pending = 1'b1;
         end
      end
   end

   assign term_valid = valid_ff[3];
   assign term       = term_ff;
   assign term_ctrl  = ctrl_ff[3];

endmodule

// ===== hdl/tkds_rank_cell.sv =====
module tkds_rank_cell (
   input  logic                    clock,
   input  tkds_pkg::cell_cmd_type  cmd,
   input  logic                    occupied,
   input  logic                    prev_ins,
   input  tkds_pkg::entry_type     prev_entry,
   input  tkds_pkg::entry_type     next_entry,
   output tkds_pkg::entry_type     entry,
   output logic                    ins
);
   import tkds_pkg::*;

   entry_type entry_ff, entry_in;

   // new score goes ahead of this entry only when strictly better
   assign ins = !occupied || (entry_ff.score > cmd.entry.score);

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (ins && prev_ins) begin
               entry_in = prev_entry;
            end else if (ins) begin
               entry_in = cmd.entry;
            end
         end
         CELL_SHIFT_OUT: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/top_k_tile_distance_search_top.sv =====
// channel   ports                      transaction
// --------  -------------------------  ----------------------------------------
// request   start, busy, req_data      pixel pair, taken when start && !busy
// response  rsp_strobe, rsp_data       ranked tile, one cycle per strobe
// config    csr_we, csr_wdata          best_count, written when csr_we is high
//
// One pixel pair per cycle while busy is low; each goes through a four-stage
// distance pipeline (differences, luma and channel sum, squaring multiplier,
// rounding), then is accumulated and, on the last pixel, inserted into the rank
// chain. The last pixel of the last tile holds busy while it is in the pipeline
// and while the chain shifts results out best first, one per kept tile.
// Reset is synchronous; the receiver cannot stall the responses.
module top_k_tile_distance_search_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tkds_pkg::req_type              req_data,
   output logic                           rsp_strobe,
   output tkds_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [tkds_pkg::CFG_W-1:0]     csr_wdata
);
   import tkds_pkg::*;

   logic                 term_valid;
   logic [TERM_W-1:0]    term;
   tile_ctrl_type        term_ctrl;
   logic                 end_pending;

   logic [CFG_W-1:0]     best_count_ff, best_count_in;
   logic [SCORE_W-1:0]   tile_sum_ff, tile_sum_in;
   logic [CNT_W-1:0]     filled_ff, filled_in;
   logic                 emit_active_ff, emit_active_in;
   logic [CNT_W-1:0]     emit_left_ff, emit_left_in;
   logic [CNT_W-1:0]     place_ff, place_in;

   logic [CNT_W-1:0]     limit, kept, kept_after;
   logic [SCORE_W:0]     sum_wide;
   logic [SCORE_W-1:0]   sum_sat;
   logic                 insert;
   cell_cmd_type         cmd;

   entry_type            entries [KEEP_MAX];
   logic [KEEP_MAX-1:0]  ins;
   logic [KEEP_MAX-1:0]  occupied;

   tkds_pixel_term u_pixel_term (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start && !busy),
      .in_data     (req_data),
      .term_valid  (term_valid),
      .term        (term),
      .term_ctrl   (term_ctrl),
      .end_pending (end_pending)
   );

   always_comb begin
      if (best_count_ff == '0) begin
         limit = CNT_W'(1);
      end else if (int'(best_count_ff) > KEEP_MAX) begin
         limit = CNT_W'(KEEP_MAX);
      end else begin
         limit = CNT_W'(best_count_ff);
      end
      kept       = (filled_ff < limit) ? filled_ff : limit;
      kept_after = (kept < limit) ? kept + CNT_W'(1) : limit;

      sum_wide = {1'b0, tile_sum_ff} + (SCORE_W + 1)'(term);
      sum_sat  = sum_wide[SCORE_W] ? SCORE_MAX : sum_wide[SCORE_W-1:0];
      insert   = term_valid && term_ctrl.last_pixel;

      cmd.entry.score = sum_sat;
      cmd.entry.tile  = term_ctrl.tile;
      priority if (emit_active_ff) begin
         cmd.op = CELL_SHIFT_OUT;
      end else if (insert) begin
         cmd.op = CELL_INSERT;
      end else begin
         cmd.op = CELL_HOLD;
      end

      best_count_in  = csr_we ? csr_wdata : best_count_ff;
      tile_sum_in    = tile_sum_ff;
      filled_in      = filled_ff;
      emit_active_in = emit_active_ff;
      emit_left_in   = emit_left_ff;
      place_in       = place_ff;

      if (term_valid) begin
         tile_sum_in = term_ctrl.last_pixel ? '0 : sum_sat;
      end
      if (emit_active_ff) begin
         emit_left_in = emit_left_ff - CNT_W'(1);
         place_in     = place_ff + CNT_W'(1);
         if (emit_left_ff == CNT_W'(1)) begin
            emit_active_in = 1'b0;
         end
      end else if (insert) begin
         if (term_ctrl.last_tile) begin
            filled_in      = '0;
            emit_active_in = 1'b1;
            emit_left_in   = kept_after;
            place_in       = '0;
         end else begin
            filled_in = kept_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_count_ff  <= BEST_COUNT_RST;
         tile_sum_ff    <= '0;
         filled_ff      <= '0;
         emit_active_ff <= 1'b0;
         emit_left_ff   <= '0;
         place_ff       <= '0;
      end else begin
         best_count_ff  <= best_count_in;
         tile_sum_ff    <= tile_sum_in;
         filled_ff      <= filled_in;
         emit_active_ff <= emit_active_in;
         emit_left_ff   <= emit_left_in;
         place_ff       <= place_in;
      end
   end

   for (genvar i = 0; i < KEEP_MAX; i++) begin : g_cell
      assign occupied[i] = CNT_W'(i) < kept;
      if (i == 0) begin : g_head
         tkds_rank_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occupied[i]),
            .prev_ins   (1'b0),
            .prev_entry ('0),
            .next_entry ((KEEP_MAX > 1) ? entries[(KEEP_MAX > 1) ? 1 : 0] : entries[0]),
            .entry      (entries[i]),
            .ins        (ins[i])
         );
      end else if (i == KEEP_MAX - 1) begin : g_tail
         tkds_rank_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occupied[i]),
            .prev_ins   (ins[i-1]),
            .prev_entry (entries[i-1]),
            .next_entry (entries[i]),
            .entry      (entries[i]),
            .ins        (ins[i])
         );
      end else begin : g_mid
         tkds_rank_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occupied[i]),
            .prev_ins   (ins[i-1]),
            .prev_entry (entries[i-1]),
            .next_entry (entries[i+1]),
            .entry      (entries[i]),
            .ins        (ins[i])
         );
      end
   end

   assign busy       = emit_active_ff || end_pending;
   assign rsp_strobe = emit_active_ff;

   always_comb begin
      rsp_data.rank_score  = entries[0].score;
      rsp_data.rank_tile   = NUMBER_W'(entries[0].tile);
      rsp_data.rank_place  = PLACE_W'(place_ff);
      rsp_data.last_result = (emit_left_ff == CNT_W'(1));
   end

endmodule

// ===== hdl/tkds_checker.sv =====
module tkds_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tkds_pkg::req_type req_data,
   input logic              rsp_strobe,
   input tkds_pkg::rsp_type rsp_data
);
   import tkds_pkg::*;

   // results only come out while requests are held off
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response while not busy");

   a_burst_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_result |=> rsp_strobe)
      else $error("response burst broken before last result");

   a_place_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_result |=>
         rsp_data.rank_place == PLACE_W'($past(rsp_data.rank_place) + 1'b1))
      else $error("rank place not consecutive");

   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_result |=> !rsp_strobe)
      else $error("response after last result");

   a_query_end_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last_pixel && req_data.last_tile |=> busy)
      else $error("query end not followed by busy");

endmodule

bind top_k_tile_distance_search_top tkds_checker u_tkds_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
